[design/txenc_pkg.sv]
// Package for the text encoding detector: result codes, byte constants and lead-byte decode.
package txenc_pkg;

  localparam int unsigned EncW = 3;
  localparam int unsigned BomW = 2;
  localparam int unsigned ContW = 3;
  localparam int unsigned PosW = 2;
  localparam int unsigned HeadDepth = 3;

  typedef logic [EncW-1:0] enc_t;
  typedef logic [BomW-1:0] bom_t;
  typedef logic [ContW-1:0] cont_t;

  localparam enc_t ENC_EMPTY   = 3'd0;
  localparam enc_t ENC_UTF8    = 3'd1;
  localparam enc_t ENC_UTF16LE = 3'd2;
  localparam enc_t ENC_UTF16BE = 3'd3;
  localparam enc_t ENC_ANSI    = 3'd4;

  localparam bom_t BOM_NONE  = 2'd0;
  localparam bom_t BOM_UTF16 = 2'd2;
  localparam bom_t BOM_UTF8  = 2'd3;

  localparam logic [7:0] BOM8_B0   = 8'hEF;
  localparam logic [7:0] BOM8_B1   = 8'hBB;
  localparam logic [7:0] BOM8_B2   = 8'hBF;
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_FE   = 8'hFE;
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;
  localparam logic [7:0] LEAD5_MAX = 8'hFB;
  localparam logic [7:0] LEAD6_MAX = 8'hFD;
  localparam logic [7:0] CONT_MIN  = 8'h80;
  localparam logic [7:0] CONT_MAX  = 8'hBF;

  typedef struct packed {
    logic  bad;
    cont_t count;
  } lead_t;

  // Decode a lead byte into the number of continuation bytes it announces.
  function automatic lead_t decode_lead(input logic [7:0] c);
    lead_t r;
    r.bad = 1'b0;
    r.count = '0;
    priority if (c <= ASCII_MAX) r.count = 3'd0;
    else if (c < LEAD2_MIN)      r.bad = 1'b1;
    else if (c <= LEAD2_MAX)     r.count = 3'd1;
    else if (c <= LEAD3_MAX)     r.count = 3'd2;
    else if (c <= LEAD4_MAX)     r.count = 3'd3;
    else if (c <= LEAD5_MAX)     r.count = 3'd4;
    else if (c <= LEAD6_MAX)     r.count = 3'd5;
    else                         r.bad = 1'b1;
    return r;
  endfunction

endpackage

[design/text_encoding_detector.sv]
// Text encoding detector: byte order mark capture, UTF-8 sequence checker, result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in      | sink      | in_valid / in_stall | data_byte[7:0], byte_present, last
//  out     | source    | out_valid/out_stall | encoding[2:0], bom_size[1:0]
//
// One beat per cycle sustained while in_stall is low: a beat lands in the input
// register, and the classify-and-update logic retires it from there into the stream
// state and, on a last beat, into the result register.
// rst is synchronous and active high; it clears valids and the stream state.
// in_stall rises only when the input register holds a last beat while a
// result is still held by a stalled output.
module text_encoding_detector
  import txenc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output enc_t       encoding,
  output bom_t       bom_size
);

  // Input register.
  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       in_reg_present;
  logic       in_reg_last;

  // Stream state.
  logic [PosW-1:0] byte_position;
  logic [7:0]      head_bytes [HeadDepth];
  logic            expect_lead;
  cont_t           continuations_left;
  logic            invalid_seen;
  logic            any_byte_seen;

  logic [PosW-1:0] byte_position_next;
  logic [7:0]      head_bytes_next [HeadDepth];
  logic            expect_lead_next;
  cont_t           continuations_left_next;
  logic            invalid_seen_next;
  logic            any_byte_seen_next;

  enc_t  enc_calc;
  bom_t  bom_calc;
  lead_t lead;
  logic  advance;
  logic  out_free;

  // The output slot frees up when empty or when its beat is taken now.
  assign out_free = !out_valid || !out_stall;
  // Retire the held beat unless it would produce a result with nowhere to go.
  assign advance  = in_reg_valid && (!in_reg_last || out_free);
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg_byte    <= data_byte;
      in_reg_present <= byte_present;
      in_reg_last    <= last;
    end
  end

  // Classify the held byte and update the stream state.
  always_comb begin
    byte_position_next      = byte_position;
    head_bytes_next         = head_bytes;
    expect_lead_next        = expect_lead;
    continuations_left_next = continuations_left;
    invalid_seen_next       = invalid_seen;
    any_byte_seen_next      = any_byte_seen;
    lead                    = decode_lead(in_reg_byte);

    if (in_reg_present) begin
      any_byte_seen_next = 1'b1;
      // Capture the first three bytes for the mark check.
      if (byte_position < PosW'(HeadDepth)) begin
        unique case (byte_position)
          2'd0:    head_bytes_next[0] = in_reg_byte;
          2'd1:    head_bytes_next[1] = in_reg_byte;
          default: head_bytes_next[2] = in_reg_byte;
        endcase
        byte_position_next = byte_position + 2'd1;
      end
      // Skip the checker once the stream has failed.
      if (!invalid_seen) begin
        if (expect_lead) begin
          if (lead.bad) begin
            invalid_seen_next = 1'b1;
          end else begin
            continuations_left_next = lead.count;
            expect_lead_next        = (lead.count == '0);
          end
        end else if (in_reg_byte < CONT_MIN || in_reg_byte > CONT_MAX) begin
          invalid_seen_next = 1'b1;
        end else begin
          continuations_left_next = continuations_left - 3'd1;
          expect_lead_next        = (continuations_left == 3'd1);
        end
      end
    end

    // Mark wins over the checker verdict; a truncated tail still counts as UTF-8.
    bom_calc = BOM_NONE;
    priority if (!any_byte_seen_next) begin
      enc_calc = ENC_EMPTY;
    end else if (head_bytes_next[0] == BOM8_B0 && head_bytes_next[1] == BOM8_B1 &&
                 head_bytes_next[2] == BOM8_B2) begin
      enc_calc = ENC_UTF8;
      bom_calc = BOM_UTF8;
    end else if (head_bytes_next[0] == BYTE_FF && head_bytes_next[1] == BYTE_FE) begin
      enc_calc = ENC_UTF16LE;
      bom_calc = BOM_UTF16;
    end else if (head_bytes_next[0] == BYTE_FE && head_bytes_next[1] == BYTE_FF) begin
      enc_calc = ENC_UTF16BE;
      bom_calc = BOM_UTF16;
    end else if (invalid_seen_next) begin
      enc_calc = ENC_ANSI;
    end else begin
      enc_calc = ENC_UTF8;
    end
  end

  // Hold the stream state; drop it back to idle after a last beat.
  always_ff @(posedge clk) begin
    if (rst || (advance && in_reg_last)) begin
      byte_position      <= '0;
      head_bytes         <= '{default: '0};
      expect_lead        <= 1'b1;
      continuations_left <= '0;
      invalid_seen       <= 1'b0;
      any_byte_seen      <= 1'b0;
    end else if (advance) begin
      byte_position      <= byte_position_next;
      head_bytes         <= head_bytes_next;
      expect_lead        <= expect_lead_next;
      continuations_left <= continuations_left_next;
      invalid_seen       <= invalid_seen_next;
      any_byte_seen      <= any_byte_seen_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && in_reg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && in_reg_last) begin
      encoding <= enc_calc;
      bom_size <= bom_calc;
    end
  end

  // A pending sequence always has continuation bytes due.
  a_cont_pending: assert property (@(posedge clk) disable iff (rst)
    !expect_lead |-> continuations_left != '0)
    else $error("continuation count zero while mid-sequence");

  // Unfilled head slots stay zero.
  a_head_clear: assert property (@(posedge clk) disable iff (rst)
    byte_position == '0 |-> head_bytes[0] == '0 && head_bytes[1] == '0 && head_bytes[2] == '0)
    else $error("head bytes not clear at stream start");

  // A three-byte mark only goes with UTF-8.
  a_bom8: assert property (@(posedge clk) disable iff (rst)
    out_valid && bom_size == BOM_UTF8 |-> encoding == ENC_UTF8)
    else $error("three-byte mark without UTF-8");

  // Non-mark codes carry no mark size.
  a_nobom: assert property (@(posedge clk) disable iff (rst)
    out_valid && (encoding == ENC_EMPTY || encoding == ENC_ANSI) |-> bom_size == BOM_NONE)
    else $error("mark size on a non-mark result");

  // A new result appears only from a retired last beat.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && in_reg_last))
    else $error("result without a last beat");

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the text encoding detector: directed table, random streams.
`timescale 1ns / 1ps

module tb_top;
  import txenc_pkg::*;

  // One result beat: the encoding code and the byte order mark size.
  typedef struct packed {
    enc_t encoding;
    bom_t bom_size;
  } verdict_t;

  // One row of the directed table. Rows with known_result set carry the expected
  // result typed in; the others are checked against the stream tracker below.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       is_last;
    logic       known_result;
    verdict_t   want;
  } row_t;

  localparam int       DirectedRows = 24;
  localparam int       PhaseCount   = 4;
  localparam int       PhaseBeats   = 180;
  localparam int       DrainCycles  = 8;
  localparam int       WaitLimit    = 2000;
  localparam int       CycleLimit   = 100000;
  localparam verdict_t NoVerdict    = '{ENC_EMPTY, BOM_NONE};

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last;
  logic       out_valid;
  logic       out_stall;
  enc_t       encoding;
  bom_t       bom_size;

  text_encoding_detector u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .encoding     (encoding),
    .bom_size     (bom_size)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stream tracker state: what the detector should hold for the stream in flight.
  logic [1:0] head_count;
  logic [7:0] mark_head [3];
  logic       want_lead;
  cont_t      cont_due;
  logic       seq_broken;
  logic       saw_byte;

  verdict_t   pending_verdicts [$];
  logic [7:0] stream_bytes [$];
  row_t       directed_rows [DirectedRows];
  verdict_t   got_verdict;
  verdict_t   want_verdict;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int stream_beats   = 0;

  int send_idle_by_phase  [PhaseCount] = '{0, 49, 0, 23};
  int recv_stall_by_phase [PhaseCount] = '{0, 0, 49, 23};

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Drop all stream state, as the detector does after each result.
  function automatic void clear_stream();
    head_count = 2'd0;
    for (int i = 0; i < 3; i++) mark_head[i] = 8'h00;
    want_lead  = 1'b1;
    cont_due   = '0;
    seq_broken = 1'b0;
    saw_byte   = 1'b0;
  endfunction

  // Advance the UTF-8 sequence checker by one byte. A failure is sticky: once broken,
  // later bytes are not looked at. Legacy 5 and 6 byte leads (F8..FD) are accepted.
  function automatic void follow_utf8(input logic [7:0] c);
    if (seq_broken) return;
    if (want_lead) begin
      if (c <= ASCII_MAX) begin
        cont_due = 3'd0;
      end else if (c < LEAD2_MIN || c > LEAD6_MAX) begin
        seq_broken = 1'b1;
        return;
      end else if (c <= LEAD2_MAX) begin
        cont_due = 3'd1;
      end else if (c <= LEAD3_MAX) begin
        cont_due = 3'd2;
      end else if (c <= LEAD4_MAX) begin
        cont_due = 3'd3;
      end else if (c <= LEAD5_MAX) begin
        cont_due = 3'd4;
      end else begin
        cont_due = 3'd5;
      end
      want_lead = 1'b0;
    end else begin
      if (c < CONT_MIN || c > CONT_MAX) begin
        seq_broken = 1'b1;
        return;
      end
      cont_due = cont_due - 3'd1;
    end
    if (cont_due == 3'd0) want_lead = 1'b1;
  endfunction

  // Fold one accepted beat into the tracker. On a last beat, hand back the result.
  // A mark wins over the checker; missing head bytes read as zero; a truncated
  // final sequence still counts as UTF-8.
  function automatic logic absorb_beat(input logic [7:0] d, input logic p, input logic l,
                                       output verdict_t v);
    v = NoVerdict;
    if (p) begin
      if (head_count < 2'd3) begin
        mark_head[head_count] = d;
        head_count = head_count + 2'd1;
      end
      saw_byte = 1'b1;
      follow_utf8(d);
    end
    if (!l) return 1'b0;
    if (!saw_byte) begin
      v = '{ENC_EMPTY, BOM_NONE};
    end else if (mark_head[0] == BOM8_B0 && mark_head[1] == BOM8_B1 &&
                 mark_head[2] == BOM8_B2) begin
      v = '{ENC_UTF8, BOM_UTF8};
    end else if (mark_head[0] == BYTE_FF && mark_head[1] == BYTE_FE) begin
      v = '{ENC_UTF16LE, BOM_UTF16};
    end else if (mark_head[0] == BYTE_FE && mark_head[1] == BYTE_FF) begin
      v = '{ENC_UTF16BE, BOM_UTF16};
    end else if (seq_broken) begin
      v = '{ENC_ANSI, BOM_NONE};
    end else begin
      v = '{ENC_UTF8, BOM_NONE};
    end
    clear_stream();
    return 1'b1;
  endfunction

  // Drive one beat, starting at a falling edge. Idle first at the current rate,
  // then hold the payload until the detector takes it. Returns at a falling edge.
  task automatic send_beat(input logic [7:0] d, input logic p, input logic l,
                           input logic known_result, input verdict_t known);
    verdict_t v;
    logic     has_result;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= d;
    byte_present <= p;
    last         <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has_result = absorb_beat(d, p, l, v);
    if (has_result) pending_verdicts.push_back(known_result ? known : v);
    @(negedge clk);
  endtask

  // Append one well-formed UTF-8 character of n bytes.
  function automatic void add_char(input int n);
    case (n)
      1:       stream_bytes.push_back(8'($urandom_range(8'h7F, 8'h00)));
      2:       stream_bytes.push_back(8'($urandom_range(8'hDF, 8'hC2)));
      3:       stream_bytes.push_back(8'($urandom_range(8'hEF, 8'hE0)));
      4:       stream_bytes.push_back(8'($urandom_range(8'hF7, 8'hF0)));
      5:       stream_bytes.push_back(8'($urandom_range(8'hFB, 8'hF8)));
      default: stream_bytes.push_back(8'($urandom_range(8'hFD, 8'hFC)));
    endcase
    for (int i = 1; i < n; i++) stream_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
  endfunction

  function automatic void add_text(input int chars);
    int pick;
    for (int i = 0; i < chars; i++) begin
      pick = $urandom_range(19);
      // Mostly short characters, with a tail of 4, 5 and 6 byte ones.
      add_char(pick < 8 ? 1 : pick < 12 ? 2 : pick < 15 ? 3 : pick < 17 ? 4 :
               pick < 19 ? 5 : 6);
    end
  endfunction

  function automatic void add_noise(input int count);
    for (int i = 0; i < count; i++) stream_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Build the next random stream. Half open with a mark or are well-formed text;
  // the rest are broken, cut short, mark-like heads, plain noise or empty.
  function automatic void compose_stream();
    int kind;
    int spot;
    stream_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      stream_bytes.push_back(BOM8_B0);
      stream_bytes.push_back(BOM8_B1);
      stream_bytes.push_back(BOM8_B2);
      add_text($urandom_range(3));
    end else if (kind < 18) begin
      stream_bytes.push_back(BYTE_FF);
      stream_bytes.push_back(BYTE_FE);
      add_noise($urandom_range(4));
    end else if (kind < 26) begin
      stream_bytes.push_back(BYTE_FE);
      stream_bytes.push_back(BYTE_FF);
      add_noise($urandom_range(4));
    end else if (kind < 50) begin
      add_text($urandom_range(5, 1));
    end else if (kind < 64) begin
      // Corrupt one byte of a well-formed text.
      add_text($urandom_range(5, 1));
      spot = $urandom_range(stream_bytes.size() - 1);
      stream_bytes[spot] = 8'($urandom_range(255));
    end else if (kind < 74) begin
      // Cut the text short, often in the middle of a sequence.
      add_text($urandom_range(4, 1));
      if (stream_bytes.size() > 1) begin
        spot = $urandom_range(stream_bytes.size() - 1, 1);
        while (stream_bytes.size() > spot) void'(stream_bytes.pop_back());
      end
    end else if (kind < 84) begin
      // One to three head bytes drawn from the mark alphabet.
      spot = $urandom_range(3, 1);
      for (int i = 0; i < spot; i++) begin
        case ($urandom_range(4))
          0:       stream_bytes.push_back(BOM8_B0);
          1:       stream_bytes.push_back(BOM8_B1);
          2:       stream_bytes.push_back(BOM8_B2);
          3:       stream_bytes.push_back(BYTE_FF);
          default: stream_bytes.push_back(BYTE_FE);
        endcase
      end
      add_text($urandom_range(2));
    end else if (kind < 95) begin
      add_noise($urandom_range(10, 1));
    end
  endfunction

  // Send the composed stream. Sprinkle byte-less filler beats, and sometimes close
  // the stream with a byte-less last beat instead of flagging the final byte.
  task automatic send_stream();
    int   n;
    logic split_last;
    n = stream_bytes.size();
    split_last = (n == 0) || ($urandom_range(5) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) begin
        send_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NoVerdict);
        stream_beats++;
      end
      send_beat(stream_bytes[i], 1'b1, !split_last && (i == n - 1), 1'b0, NoVerdict);
      stream_beats++;
    end
    if (split_last) begin
      send_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NoVerdict);
      stream_beats++;
    end
  endtask

  // Hold the sender off until every pending result has come back.
  task automatic wait_results_drained();
    for (int i = 0; i < WaitLimit && pending_verdicts.size() != 0; i++) @(negedge clk);
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
  endtask

  // Receiver: stall at the phase's rate, changing at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result check: every beat taken at a rising edge is matched against the oldest
  // pending result, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_verdict = '{encoding, bom_size};
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result encoding %0d bom_size %0d",
                                  encoding, bom_size));
      end else begin
        want_verdict = pending_verdicts.pop_front();
        if (got_verdict.encoding !== want_verdict.encoding)
          report_mismatch($sformatf("encoding %0d, expected %0d",
                                    got_verdict.encoding, want_verdict.encoding));
        if (got_verdict.bom_size !== want_verdict.bom_size)
          report_mismatch($sformatf("bom_size %0d, expected %0d",
                                    got_verdict.bom_size, want_verdict.bom_size));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    data_byte    = 8'h00;
    byte_present = 1'b0;
    last         = 1'b0;
    out_stall    = 1'b0;
    clear_stream();

    directed_rows = '{
      // Empty stream.
      '{8'h00, 1'b0, 1'b1, 1'b1, '{ENC_EMPTY, BOM_NONE}},
      // Byte-less filler has no effect; the stream is still empty.
      '{8'hA5, 1'b0, 1'b0, 1'b0, NoVerdict},
      '{8'h5A, 1'b0, 1'b1, 1'b1, '{ENC_EMPTY, BOM_NONE}},
      // UTF-8 mark.
      '{BOM8_B0, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{BOM8_B1, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{BOM8_B2, 1'b1, 1'b1, 1'b1, '{ENC_UTF8, BOM_UTF8}},
      // UTF-16LE mark, whatever the checker thinks of FF.
      '{BYTE_FF, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{BYTE_FE, 1'b1, 1'b1, 1'b1, '{ENC_UTF16LE, BOM_UTF16}},
      // UTF-16BE mark followed by content.
      '{BYTE_FE, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{BYTE_FF, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{8'h41, 1'b1, 1'b1, 1'b1, '{ENC_UTF16BE, BOM_UTF16}},
      // Single-byte streams: missing head bytes read as zero.
      '{8'h00, 1'b1, 1'b1, 1'b1, '{ENC_UTF8, BOM_NONE}},
      '{8'hFF, 1'b1, 1'b1, 1'b1, '{ENC_ANSI, BOM_NONE}},
      // Two thirds of the UTF-8 mark: a truncated sequence, still UTF-8.
      '{BOM8_B0, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{BOM8_B1, 1'b1, 1'b1, 1'b0, NoVerdict},
      // Continuation byte in lead position.
      '{8'h80, 1'b1, 1'b1, 1'b1, '{ENC_ANSI, BOM_NONE}},
      // Legacy six-byte sequence.
      '{8'hFD, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{8'hBF, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{8'hBF, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{8'hBF, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{8'hBF, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{8'hBF, 1'b1, 1'b1, 1'b0, NoVerdict},
      // Open two-byte sequence closed by a byte-less last beat.
      '{8'hC2, 1'b1, 1'b0, 1'b0, NoVerdict},
      '{8'h55, 1'b0, 1'b1, 1'b0, NoVerdict}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, no idling on either side.
    for (int i = 0; i < DirectedRows; i++)
      send_beat(directed_rows[i].data, directed_rows[i].present, directed_rows[i].is_last,
                directed_rows[i].known_result, directed_rows[i].want);
    in_valid <= 1'b0;
    wait_results_drained();

    // Random streams, one idling pattern per phase. Each phase starts from a fully
    // drained detector, so the sender also sits out a full return of results.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      send_idle_pct  = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      stream_beats   = 0;
      while (stream_beats < PhaseBeats) begin
        compose_stream();
        send_stream();
      end
      in_valid <= 1'b0;
      wait_results_drained();
    end

    // Let any stray result surface before the verdict.
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/txenc_pkg.sv
design/text_encoding_detector.sv
bench/tb_top.sv
